>>> sv/miu_pkg.sv
`timescale 1ns / 1ps
package miu_pkg;

  localparam logic [4:0] ACT_ADD32 = 5'd0;
  localparam logic [4:0] ACT_ADD64 = 5'd1;
  localparam logic [4:0] ACT_SUB32 = 5'd2;
  localparam logic [4:0] ACT_SUB64 = 5'd3;
  localparam logic [4:0] ACT_MULT  = 5'd4;
  localparam logic [4:0] ACT_DIV   = 5'd5;
  localparam logic [4:0] ACT_MOVZ  = 5'd6;
  localparam logic [4:0] ACT_MOVN  = 5'd7;
  localparam logic [4:0] ACT_SLTI  = 5'd8;
  localparam logic [4:0] ACT_SLT   = 5'd9;
  localparam logic [4:0] ACT_BEQ   = 5'd10;
  localparam logic [4:0] ACT_BNE   = 5'd11;
  localparam logic [4:0] ACT_BGEZ  = 5'd12;
  localparam logic [4:0] ACT_BLTZ  = 5'd13;
  localparam logic [4:0] ACT_BLEZ  = 5'd14;
  localparam logic [4:0] ACT_BGTZ  = 5'd15;
  localparam logic [4:0] ACT_SET   = 5'd16;

  localparam int NumRegs   = 32;
  localparam int RegWidth  = 64;
  localparam int QueueDepth = 2;

  localparam logic [31:0] WordOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] WordMin  = 32'h8000_0000;

  typedef struct packed {
    logic [4:0]  action;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  widx;
    logic [15:0] imm;
    logic        sgn;
    logic        unit;
    logic        half;
    logic        likely;
    logic [63:0] load;
  } req_t;

  function automatic logic [63:0] sext32(input logic [31:0] w);
    sext32 = {{32{w[31]}}, w};
  endfunction

  function automatic logic [63:0] place_word(input logic wide, input logic [63:0] old,
                                             input logic [31:0] w);
    place_word = wide ? sext32(w) : {old[63:32], w};
  endfunction

endpackage

>>> sv/miu_ram.sv
`timescale 1ns / 1ps
module miu_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/miu_front.sv
`timescale 1ns / 1ps
module miu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [4:0]        action_i,
  input  logic [4:0]        rs_index_i,
  input  logic [4:0]        rt_index_i,
  input  logic [4:0]        rd_index_i,
  input  logic [15:0]       immediate_i,
  input  logic              signed_op_i,
  input  logic              unit_select_i,
  input  logic              word_half_i,
  input  logic              likely_i,
  input  logic [63:0]       load_value_i,
  output logic              head_valid_o,
  output miu_pkg::req_t     head_o,
  input  logic              head_pop_i
);
  import miu_pkg::*;

  req_t       slot_q [QueueDepth];
  req_t       req;
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  // classify: slti writes rt, everything else rd
  always_comb begin
    req.action = action_i;
    req.rs     = rs_index_i;
    req.rt     = rt_index_i;
    req.widx   = (action_i == ACT_SLTI) ? rt_index_i : rd_index_i;
    req.imm    = immediate_i;
    req.sgn    = signed_op_i;
    req.unit   = unit_select_i;
    req.half   = word_half_i;
    req.likely = likely_i;
    req.load   = load_value_i;
  end

  assign full         = (count_q == 2'(QueueDepth));
  assign do_push      = push && !full;
  assign head_valid_o = (count_q != 2'd0);
  assign do_pop       = head_pop_i && head_valid_o;
  assign head_o       = slot_q[rptr_q];
  assign count_d      = count_q + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      count_q <= count_d;
    end
  end
endmodule

>>> sv/miu_back.sv
`timescale 1ns / 1ps
module miu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              head_valid_i,
  input  miu_pkg::req_t     head_i,
  output logic              head_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic              write_enable_o,
  output logic [4:0]        write_index_o,
  output logic [63:0]       result_value_o,
  output logic [63:0]       lo_out_o,
  output logic [63:0]       hi_out_o,
  output logic              branch_taken_o,
  output logic              annul_slot_o,
  output logic              reserved_fault_o
);
  import miu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RS   = 3'd1;
  localparam logic [2:0] S_RT   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DFIN = 3'd7;

  logic [2:0]  state_q, state_d;
  req_t        cur_q;
  logic        mode_q;
  logic [NumRegs-1:0] valid_q;
  logic        rvld_q;
  logic [4:0]  raddr;
  logic [63:0] rdata, opnd;
  logic [63:0] a_q, b_q, old_q;
  logic [63:0] prod_q;
  logic [63:0] lo_q [2];
  logic [63:0] hi_q [2];
  logic [31:0] dn_q;
  logic [32:0] rem_q;
  logic [4:0]  cnt_q;

  logic        out_valid_q;
  logic        o_we_q, o_taken_q, o_annul_q, o_fault_q;
  logic [4:0]  o_widx_q;
  logic [63:0] o_val_q, o_lo_q, o_hi_q;

  logic        start, fin, is_muldiv;
  logic [32:0] x33, y33;
  logic signed [65:0] prod_full;
  logic [31:0] n_w, d_w, un_w, ud_w;
  logic        nn, nd, d_zero, d_ovf;
  logic [32:0] rem_sh;
  logic        q_bit;
  logic [31:0] q_fin, r_fin;
  logic [63:0] lo_sel, hi_sel, lo_n, hi_n;
  logic        we, branch, taken, fault, lt, zero, eq, neg, le, upd_lohi;
  logic [63:0] val, rhs, v_le;
  logic        rf_we;

  assign empty     = !out_valid_q;
  assign start     = (state_q == S_IDLE) && head_valid_i && !out_valid_q;
  assign head_pop_o = start;
  assign is_muldiv = (cur_q.action == ACT_MULT) || (cur_q.action == ACT_DIV);
  assign fin       = ((state_q == S_EX) && !is_muldiv) || (state_q == S_MUL) ||
                     (state_q == S_DFIN);

  always_comb begin
    unique case (state_q)
      S_IDLE:  raddr = head_i.rs;
      S_RS:    raddr = cur_q.rt;
      S_RT:    raddr = cur_q.widx;
      default: raddr = cur_q.rs;
    endcase
  end

  miu_ram #(.Width(RegWidth), .Depth(NumRegs)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (cur_q.widx),
    .wdata_i (val),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // never-written registers read as zero
  assign opnd = rvld_q ? rdata : 64'd0;

  // multiply operands
  assign x33       = cur_q.sgn ? {a_q[31], a_q[31:0]} : {1'b0, a_q[31:0]};
  assign y33       = cur_q.sgn ? {b_q[31], b_q[31:0]} : {1'b0, b_q[31:0]};
  assign prod_full = $signed(x33) * $signed(y33);

  // divide operands and special cases
  assign n_w    = cur_q.half ? a_q[63:32] : a_q[31:0];
  assign d_w    = cur_q.half ? b_q[63:32] : b_q[31:0];
  assign nn     = cur_q.sgn && n_w[31];
  assign nd     = cur_q.sgn && d_w[31];
  assign un_w   = nn ? (32'd0 - n_w) : n_w;
  assign ud_w   = nd ? (32'd0 - d_w) : d_w;
  assign d_zero = (d_w == 32'd0);
  assign d_ovf  = cur_q.sgn && (n_w == WordMin) && (d_w == WordOnes);
  assign rem_sh = {rem_q[31:0], dn_q[31]};
  assign q_bit  = (rem_sh >= {1'b0, ud_w});

  always_comb begin
    if (d_zero) begin
      q_fin = nn ? 32'd1 : WordOnes;
      r_fin = n_w;
    end else if (d_ovf) begin
      q_fin = WordMin;
      r_fin = 32'd0;
    end else begin
      q_fin = (nn != nd) ? (32'd0 - dn_q) : dn_q;
      r_fin = nn ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
    end
  end

  assign lo_sel = lo_q[cur_q.unit];
  assign hi_sel = hi_q[cur_q.unit];

  always_comb begin
    we       = 1'b0;
    val      = 64'd0;
    branch   = 1'b0;
    taken    = 1'b0;
    fault    = 1'b0;
    upd_lohi = 1'b0;
    lo_n     = lo_sel;
    hi_n     = hi_sel;
    rhs      = (cur_q.action == ACT_SLTI) ? {{48{cur_q.imm[15]}}, cur_q.imm} : b_q;
    if (mode_q) begin
      lt = cur_q.sgn ? ($signed(a_q) < $signed(rhs)) : (a_q < rhs);
    end else begin
      lt = cur_q.sgn ? ($signed(a_q[31:0]) < $signed(rhs[31:0])) : (a_q[31:0] < rhs[31:0]);
    end
    zero = mode_q ? (b_q == 64'd0) : (b_q[31:0] == 32'd0);
    eq   = mode_q ? (a_q == b_q) : (a_q[31:0] == b_q[31:0]);
    neg  = mode_q ? a_q[63] : a_q[31];
    v_le = mode_q ? a_q : sext32(a_q[31:0]);
    le   = (v_le == 64'd0) || v_le[63];
    unique case (cur_q.action) inside
      ACT_ADD32: begin
        val = place_word(mode_q, old_q, a_q[31:0] + b_q[31:0]);
        we  = 1'b1;
      end
      ACT_SUB32: begin
        val = place_word(mode_q, old_q, a_q[31:0] - b_q[31:0]);
        we  = 1'b1;
      end
      ACT_ADD64, ACT_SUB64: begin
        if (!mode_q) begin
          fault = 1'b1;
        end else begin
          val = (cur_q.action == ACT_ADD64) ? a_q + b_q : a_q - b_q;
          we  = 1'b1;
        end
      end
      ACT_MULT: begin
        lo_n     = place_word(mode_q, lo_sel, prod_q[31:0]);
        hi_n     = place_word(mode_q, hi_sel, prod_q[63:32]);
        upd_lohi = 1'b1;
        val      = lo_n;
        we       = 1'b1;
      end
      ACT_DIV: begin
        lo_n     = place_word(mode_q, lo_sel, q_fin);
        hi_n     = place_word(mode_q, hi_sel, r_fin);
        upd_lohi = 1'b1;
      end
      ACT_MOVZ, ACT_MOVN: begin
        if (zero == (cur_q.action == ACT_MOVZ)) begin
          val = mode_q ? a_q : {old_q[63:32], a_q[31:0]};
          we  = 1'b1;
        end
      end
      ACT_SLTI, ACT_SLT: begin
        val = mode_q ? {63'd0, lt} : {old_q[63:32], 31'd0, lt};
        we  = 1'b1;
      end
      ACT_BEQ, ACT_BNE: begin
        branch = 1'b1;
        taken  = (cur_q.action == ACT_BEQ) ? eq : !eq;
      end
      ACT_BGEZ, ACT_BLTZ: begin
        branch = 1'b1;
        taken  = (cur_q.action == ACT_BGEZ) ? !neg : neg;
      end
      ACT_BLEZ, ACT_BGTZ: begin
        branch = 1'b1;
        taken  = (cur_q.action == ACT_BLEZ) ? le : !le;
      end
      ACT_SET: begin
        val = cur_q.load;
        we  = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    // register zero is never written
    if (cur_q.widx == 5'd0) we = 1'b0;
    if (!we) val = 64'd0;
  end

  assign rf_we = fin && we;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_RS;
      S_RS:    state_d = S_RT;
      S_RT:    state_d = S_RD;
      S_RD:    state_d = S_EX;
      S_EX: begin
        if (cur_q.action == ACT_MULT) state_d = S_MUL;
        else if (cur_q.action == ACT_DIV) state_d = S_DIV;
        else state_d = S_IDLE;
      end
      S_MUL:   state_d = S_IDLE;
      S_DIV:   if (cnt_q == 5'd31) state_d = S_DFIN;
      S_DFIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start) cur_q <= head_i;
    if (state_q == S_RS) a_q <= opnd;
    if (state_q == S_RT) b_q <= opnd;
    if (state_q == S_RD) old_q <= opnd;
    if (state_q == S_EX) begin
      prod_q <= prod_full[63:0];
      dn_q   <= un_w;
      rem_q  <= 33'd0;
    end
    if (state_q == S_DIV) begin
      dn_q  <= {dn_q[30:0], q_bit};
      rem_q <= q_bit ? (rem_sh - {1'b0, ud_w}) : rem_sh;
    end
    if (fin) begin
      o_we_q    <= we;
      o_widx_q  <= we ? cur_q.widx : 5'd0;
      o_val_q   <= val;
      o_lo_q    <= lo_n;
      o_hi_q    <= hi_n;
      o_taken_q <= branch && taken;
      o_annul_q <= branch && cur_q.likely && !taken;
      o_fault_q <= fault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b1;
      valid_q     <= '0;
      rvld_q      <= 1'b0;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
      lo_q[0]     <= 64'd0;
      lo_q[1]     <= 64'd0;
      hi_q[0]     <= 64'd0;
      hi_q[1]     <= 64'd0;
    end else begin
      state_q <= state_d;
      rvld_q  <= valid_q[raddr];
      if (cfg_we_i) mode_q <= cfg_data_i;
      if (state_q == S_EX) cnt_q <= 5'd0;
      else if (state_q == S_DIV) cnt_q <= cnt_q + 5'd1;
      if (rf_we) valid_q[cur_q.widx] <= 1'b1;
      if (fin && upd_lohi) begin
        lo_q[cur_q.unit] <= lo_n;
        hi_q[cur_q.unit] <= hi_n;
      end
      if (fin) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  assign write_enable_o   = o_we_q;
  assign write_index_o    = o_widx_q;
  assign result_value_o   = o_val_q;
  assign lo_out_o         = o_lo_q;
  assign hi_out_o         = o_hi_q;
  assign branch_taken_o   = o_taken_q;
  assign annul_slot_o     = o_annul_q;
  assign reserved_fault_o = o_fault_q;
endmodule

>>> sv/mips_integer_execute_unit.sv
`timescale 1ns / 1ps
// Integer execute unit: one instruction request in, one result out.
// Input channel: drive the fields and raise push; the request is taken on a
// clock edge where push is high and full is low. A two-entry queue holds
// requests while the execute side is busy.
// Result channel: while empty is low the oldest result is on the output ports;
// it is taken on an edge where pop is high. A result waits as long as the
// receiver does not pop, and the execute side holds its next request meanwhile.
// Flow: a request waits in the queue; the RS, RT and RD states then read rs,
// rt and the destination from the register file RAM (one read port), and the
// EX state executes. Multiply adds the MUL state for the registered product;
// divide adds the bit-serial quotient loop (DIV) and the DFIN state. A new
// request starts only after the previous result is popped, so throughput is
// set by the single RAM read port, the divide loop and the pop of each result.
// Configuration: cfg_we_i writes register_mode from cfg_data_i; the user must
// do so only while idle, and the block does not enforce it.
// Reset: the queue and result empty, register_mode 64-bit, all general and
// LO/HI registers read as zero.
module mips_integer_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  action_i,
  input  logic [4:0]  rs_index_i,
  input  logic [4:0]  rt_index_i,
  input  logic [4:0]  rd_index_i,
  input  logic [15:0] immediate_i,
  input  logic        signed_op_i,
  input  logic        unit_select_i,
  input  logic        word_half_i,
  input  logic        likely_i,
  input  logic [63:0] load_value_i,
  output logic        empty,
  input  logic        pop,
  output logic        write_enable_o,
  output logic [4:0]  write_index_o,
  output logic [63:0] result_value_o,
  output logic [63:0] lo_out_o,
  output logic [63:0] hi_out_o,
  output logic        branch_taken_o,
  output logic        annul_slot_o,
  output logic        reserved_fault_o
);
  import miu_pkg::*;

  logic head_valid, head_pop;
  req_t head;

  miu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .rs_index_i    (rs_index_i),
    .rt_index_i    (rt_index_i),
    .rd_index_i    (rd_index_i),
    .immediate_i   (immediate_i),
    .signed_op_i   (signed_op_i),
    .unit_select_i (unit_select_i),
    .word_half_i   (word_half_i),
    .likely_i      (likely_i),
    .load_value_i  (load_value_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .head_pop_i    (head_pop)
  );

  miu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .head_pop_o       (head_pop),
    .empty            (empty),
    .pop              (pop),
    .write_enable_o   (write_enable_o),
    .write_index_o    (write_index_o),
    .result_value_o   (result_value_o),
    .lo_out_o         (lo_out_o),
    .hi_out_o         (hi_out_o),
    .branch_taken_o   (branch_taken_o),
    .annul_slot_o     (annul_slot_o),
    .reserved_fault_o (reserved_fault_o)
  );
endmodule

>>> sv/miu_checker.sv
`timescale 1ns / 1ps
module miu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        write_enable_o,
  input logic [4:0]  write_index_o,
  input logic [63:0] result_value_o,
  input logic        branch_taken_o,
  input logic        annul_slot_o,
  input logic        reserved_fault_o
);
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result present during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_value_o)))
    else $error("stalled result changed");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !write_enable_o) |-> (write_index_o == 5'd0 && result_value_o == 64'd0))
    else $error("idle write fields not zero");

  a_branch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(branch_taken_o && annul_slot_o))
    else $error("taken branch annulled");

  a_fault_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && reserved_fault_o) |-> (!write_enable_o && !branch_taken_o))
    else $error("faulted request wrote");
endmodule

bind mips_integer_execute_unit miu_checker u_miu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .write_enable_o   (write_enable_o),
  .write_index_o    (write_index_o),
  .result_value_o   (result_value_o),
  .branch_taken_o   (branch_taken_o),
  .annul_slot_o     (annul_slot_o),
  .reserved_fault_o (reserved_fault_o)
);

>>> tb/mips_integer_execute_unit_checker.sv
`timescale 1ns / 1ps
module mips_integer_execute_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [4:0]  action_i,
  input  logic [4:0]  rs_index_i,
  input  logic [4:0]  rt_index_i,
  input  logic [4:0]  rd_index_i,
  input  logic [15:0] immediate_i,
  input  logic        signed_op_i,
  input  logic        unit_select_i,
  input  logic        word_half_i,
  input  logic        likely_i,
  input  logic [63:0] load_value_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        write_enable_i,
  input  logic [4:0]  write_index_i,
  input  logic [63:0] result_value_i,
  input  logic [63:0] lo_out_i,
  input  logic [63:0] hi_out_i,
  input  logic        branch_taken_i,
  input  logic        annul_slot_i,
  input  logic        reserved_fault_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          retired_o
);
  import miu_pkg::*;

  typedef struct packed {
    logic        we;
    logic [4:0]  widx;
    logic [63:0] val;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        taken;
    logic        annul;
    logic        fault;
  } retire_t;

  logic [63:0] gpr [NumRegs];
  logic [63:0] lo_q [2];
  logic [63:0] hi_q [2];
  logic        wide_mode;
  retire_t     expected_q [$];

  function automatic logic [63:0] sx(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  function automatic logic [63:0] merge_word(input logic [63:0] old, input logic [31:0] w);
    return wide_mode ? sx(w) : {old[63:32], w};
  endfunction

  function automatic logic lt_cmp(input logic [63:0] a, input logic [63:0] b, input logic sg);
    logic [63:0] x, y;
    x = a;
    y = b;
    if (!wide_mode) begin
      x = sg ? sx(a[31:0]) : {32'd0, a[31:0]};
      y = sg ? sx(b[31:0]) : {32'd0, b[31:0]};
    end
    if (sg) return $signed(x) < $signed(y);
    return x < y;
  endfunction

  function automatic retire_t execute_request();
    retire_t r;
    logic [63:0] a, b, p, v;
    logic [31:0] n, d, q, rm, un, ud;
    logic ok, eq, neg, le;
    logic [4:0] w;
    a = gpr[rs_index_i];
    b = gpr[rt_index_i];
    r = '0;
    w = rd_index_i;
    ok = 1'b0;
    v = '0;
    case (action_i)
      ACT_ADD32, ACT_SUB32: begin
        p = (action_i == ACT_ADD32) ? a + b : a - b;
        v = merge_word(gpr[rd_index_i], p[31:0]);
        ok = 1'b1;
      end
      ACT_ADD64, ACT_SUB64: begin
        if (!wide_mode) r.fault = 1'b1;
        else begin
          v = (action_i == ACT_ADD64) ? a + b : a - b;
          ok = 1'b1;
        end
      end
      ACT_MULT: begin
        if (signed_op_i) p = $signed(sx(a[31:0])) * $signed(sx(b[31:0]));
        else p = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        lo_q[unit_select_i] = merge_word(lo_q[unit_select_i], p[31:0]);
        hi_q[unit_select_i] = merge_word(hi_q[unit_select_i], p[63:32]);
        v = lo_q[unit_select_i];
        ok = 1'b1;
      end
      ACT_DIV: begin
        n = word_half_i ? a[63:32] : a[31:0];
        d = word_half_i ? b[63:32] : b[31:0];
        if (d == 0) begin
          q = (signed_op_i && n[31]) ? 32'd1 : WordOnes;
          rm = n;
        end else if (signed_op_i && n == WordMin && d == WordOnes) begin
          q = WordMin;
          rm = 0;
        end else if (signed_op_i) begin
          un = n[31] ? -n : n;
          ud = d[31] ? -d : d;
          q = un / ud;
          rm = un % ud;
          if (n[31] != d[31]) q = -q;
          if (n[31]) rm = -rm;
        end else begin
          q = n / d;
          rm = n % d;
        end
        lo_q[unit_select_i] = merge_word(lo_q[unit_select_i], q);
        hi_q[unit_select_i] = merge_word(hi_q[unit_select_i], rm);
      end
      ACT_MOVZ, ACT_MOVN: begin
        eq = wide_mode ? (b == 0) : (b[31:0] == 0);
        if (eq == (action_i == ACT_MOVZ)) begin
          v = wide_mode ? a : {gpr[rd_index_i][63:32], a[31:0]};
          ok = 1'b1;
        end
      end
      ACT_SLTI, ACT_SLT: begin
        p = (action_i == ACT_SLTI) ? {{48{immediate_i[15]}}, immediate_i} : b;
        if (action_i == ACT_SLTI) w = rt_index_i;
        v = {63'd0, lt_cmp(a, p, signed_op_i)};
        if (!wide_mode) v[63:32] = gpr[w][63:32];
        ok = 1'b1;
      end
      ACT_BEQ, ACT_BNE: begin
        eq = wide_mode ? (a == b) : (a[31:0] == b[31:0]);
        r.taken = (action_i == ACT_BEQ) ? eq : !eq;
        r.annul = likely_i && !r.taken;
      end
      ACT_BGEZ, ACT_BLTZ: begin
        neg = wide_mode ? a[63] : a[31];
        r.taken = (action_i == ACT_BGEZ) ? !neg : neg;
        r.annul = likely_i && !r.taken;
      end
      ACT_BLEZ, ACT_BGTZ: begin
        p = wide_mode ? a : sx(a[31:0]);
        le = (p == 0) || p[63];
        r.taken = (action_i == ACT_BLEZ) ? le : !le;
        r.annul = likely_i && !r.taken;
      end
      ACT_SET: begin
        v = load_value_i;
        ok = 1'b1;
      end
      default: ;
    endcase
    if (ok && w != 0) begin
      gpr[w] = v;
      r.we = 1'b1;
      r.widx = w;
      r.val = v;
    end
    r.lo = lo_q[unit_select_i];
    r.hi = hi_q[unit_select_i];
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    retire_t got, exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) gpr[i] = '0;
      lo_q[0] = '0; lo_q[1] = '0; hi_q[0] = '0; hi_q[1] = '0;
      wide_mode = 1'b1;
      expected_q.delete();
      fail_count_o = 0;
      retired_o = 0;
    end else begin
      if (cfg_we_i) wide_mode = cfg_data_i;
      if (push_i && !full_i) expected_q.push_back(execute_request());
      if (pop_i && !empty_i) begin
        got = '{write_enable_i, write_index_i, result_value_i, lo_out_i, hi_out_i,
                branch_taken_i, annul_slot_i, reserved_fault_i};
        retired_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.we !== exp_r.we || got.widx !== exp_r.widx || got.val !== exp_r.val ||
              got.lo !== exp_r.lo || got.hi !== exp_r.hi || got.taken !== exp_r.taken ||
              got.annul !== exp_r.annul || got.fault !== exp_r.fault) begin
            fail_count_o++;
            $display("%0t: mismatch expected we=%b idx=%0d val=%h lo=%h hi=%h t=%b a=%b f=%b",
                     $time, exp_r.we, exp_r.widx, exp_r.val, exp_r.lo, exp_r.hi,
                     exp_r.taken, exp_r.annul, exp_r.fault);
            $display("%0t:          actual   we=%b idx=%0d val=%h lo=%h hi=%h t=%b a=%b f=%b",
                     $time, got.we, got.widx, got.val, got.lo, got.hi,
                     got.taken, got.annul, got.fault);
          end
        end
      end
    end
  end

endmodule

>>> tb/mips_integer_execute_unit_tb.sv
`timescale 1ns / 1ps
module mips_integer_execute_unit_tb;
  import miu_pkg::*;

  logic        clk_i, rst_ni, cfg_we, cfg_data, push, full, empty, pop;
  logic [4:0]  action, rs_index, rt_index, rd_index;
  logic [15:0] immediate;
  logic        signed_op, unit_select, word_half, likely;
  logic [63:0] load_value;
  logic        write_enable, branch_taken, annul_slot, reserved_fault;
  logic [4:0]  write_index;
  logic [63:0] result_value, lo_out, hi_out;
  int          fail_count, pending, retired;
  int          send_idle_pct, stall_pct, hold_off;
  int          sent;

  mips_integer_execute_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_data_i(cfg_data), .push, .full,
    .action_i(action), .rs_index_i(rs_index), .rt_index_i(rt_index),
    .rd_index_i(rd_index), .immediate_i(immediate), .signed_op_i(signed_op),
    .unit_select_i(unit_select), .word_half_i(word_half), .likely_i(likely),
    .load_value_i(load_value), .empty, .pop, .write_enable_o(write_enable),
    .write_index_o(write_index), .result_value_o(result_value), .lo_out_o(lo_out),
    .hi_out_o(hi_out), .branch_taken_o(branch_taken), .annul_slot_o(annul_slot),
    .reserved_fault_o(reserved_fault)
  );

  mips_integer_execute_unit_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_data_i(cfg_data), .push_i(push),
    .full_i(full), .action_i(action), .rs_index_i(rs_index), .rt_index_i(rt_index),
    .rd_index_i(rd_index), .immediate_i(immediate), .signed_op_i(signed_op),
    .unit_select_i(unit_select), .word_half_i(word_half), .likely_i(likely),
    .load_value_i(load_value), .empty_i(empty), .pop_i(pop),
    .write_enable_i(write_enable), .write_index_i(write_index),
    .result_value_i(result_value), .lo_out_i(lo_out), .hi_out_i(hi_out),
    .branch_taken_i(branch_taken), .annul_slot_i(annul_slot),
    .reserved_fault_i(reserved_fault), .fail_count_o(fail_count),
    .pending_o(pending), .retired_o(retired)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stall, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      pop <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return {32'd0, WordMin};
      3: return {32'd0, WordOnes};
      4: return sext32($urandom());
      5: return 64'h8000_0000_0000_0000;
      6: return 64'($urandom_range(15));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Push stays high after a request is taken; the next request, an idle gap
  // or drain() decides its next value.
  task automatic send_request(input logic [4:0] act, input logic [4:0] rs,
                              input logic [4:0] rt, input logic [4:0] rd,
                              input logic [15:0] imm, input logic [63:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    push <= 1'b1;
    action <= act; rs_index <= rs; rt_index <= rt; rd_index <= rd;
    immediate <= imm; load_value <= val;
    signed_op <= 1'($urandom()); unit_select <= 1'($urandom());
    word_half <= 1'($urandom()); likely <= 1'($urandom());
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One request in four loads a register, the rest operate on them; a small
  // register window keeps dependences frequent.
  task automatic random_request();
    logic [4:0] act;
    if ($urandom_range(3) == 0) act = ACT_SET;
    else if ($urandom_range(19) == 0) act = 5'($urandom_range(31));
    else act = 5'($urandom_range(15));
    send_request(act, 5'($urandom_range(7)), 5'($urandom_range(7)), 5'($urandom_range(7)),
                 16'($urandom()), rand_value());
  endtask

  initial begin
    rst_ni = 1'b0; cfg_we = 1'b0; cfg_data = 1'b0; push = 1'b0; pop = 1'b0;
    action = '0; rs_index = '0; rt_index = '0; rd_index = '0; immediate = '0;
    signed_op = 1'b0; unit_select = 1'b0; word_half = 1'b0; likely = 1'b0;
    load_value = '0; send_idle_pct = 0; stall_pct = 0; hold_off = 0; sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extreme operands and every action, in both modes.
    for (int m = 1; m >= 0; m--) begin
      set_mode(m[0]);
      send_request(ACT_SET, 0, 0, 1, 16'h0000, {32'hFFFF_FFFF, WordMin});
      send_request(ACT_SET, 0, 0, 2, 16'h8000, '1);
      send_request(ACT_SET, 0, 0, 3, 16'h7FFF, 64'h0);
      send_request(ACT_SET, 0, 0, 0, 16'hFFFF, '1);
      for (int a = 0; a <= 17; a++)
        send_request(a[4:0], 1, 2, 4, (a[0] ? 16'h8000 : 16'h7FFF), '0);
      send_request(ACT_DIV, 1, 3, 5, 16'h0, '0);
      send_request(ACT_SLTI, 3, 0, 6, 16'hFFFF, '0);
      send_request(ACT_MULT, 2, 2, 0, 16'h0, '0);
      drain();
    end

    // Random phases across idle mixes and both register modes.
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 2) hold_off = 400;
      for (int i = 0; i < 235; i++) random_request();
      drain();
    end

    $display("Covered %0d requests, %0d results, all actions in 32- and 64-bit modes",
             sent, retired);
    $display("with sender gaps, receiver stalls and a long result back-pressure stretch.");
    if (fail_count == 0) $display("mips_integer_execute_unit_tb: PASS");
    else $display("mips_integer_execute_unit_tb: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("mips_integer_execute_unit_tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/miu_pkg.sv
sv/miu_ram.sv
sv/miu_front.sv
sv/miu_back.sv
sv/mips_integer_execute_unit.sv
sv/miu_checker.sv
tb/mips_integer_execute_unit_checker.sv
tb/mips_integer_execute_unit_tb.sv
